/* rtl/core/hsbd_pkg.sv */
// Shared constants, types and averaging functions of the half-scale box downsampler.
// Used by hsbd_line_store, half_scale_box_downsampler and the bench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hsbd_pkg;

   // Widest source row whose pairs all fit in the line store, and the line store that follows from it.
   localparam int MAX_WIDTH   = 4096;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   // Output column index and clamped output width need one bit more than the store address.
   localparam int OUT_COL_W   = STORE_AW + 1;
   localparam int COUNT_W     = 13;

   localparam logic [31:0] BYTE_MASK32 = 32'hfefe_fefe;
   localparam logic [15:0] MASK565     = 16'hf7de;

   // Pixel mode codes; code 3 behaves as packed.
   localparam logic [1:0] MODE_GRAY8    = 2'd0;
   localparam logic [1:0] MODE_ARGB8565 = 2'd1;
   localparam logic [1:0] MODE_PACKED   = 2'd2;
   localparam logic [1:0] MODE_PACKED_B = 2'd3;

   // One access to the line store: a write on even rows, a read on odd rows.
   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [STORE_AW-1:0] addr;
   } store_req_type;

   function automatic logic [31:0] avg_bytes(input logic [31:0] a, input logic [31:0] b);
      avg_bytes = (((a ^ b) & BYTE_MASK32) >> 1) + (a & b);
   endfunction

   function automatic logic [15:0] avg_565(input logic [15:0] a, input logic [15:0] b);
      avg_565 = (((a ^ b) & MASK565) >> 1) + (a & b);
   endfunction

   // Alpha byte plus 565 color, as used by both the pair and the row step.
   function automatic logic [31:0] avg_8565(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] al;
      logic [15:0] c;
      al = avg_bytes({24'd0, a[7:0]}, {24'd0, b[7:0]});
      c  = avg_565(a[23:8], b[23:8]);
      avg_8565 = {8'd0, c, al[7:0]};
   endfunction

   // Horizontal pair result in the form kept in the line store.
   function automatic logic [31:0] pair_of(input logic [1:0] mode,
                                           input logic [31:0] a, input logic [31:0] b);
      unique case (mode)
         MODE_GRAY8:    pair_of = {23'd0, ({1'b0, a[7:0]} + {1'b0, b[7:0]})};
         MODE_ARGB8565: pair_of = avg_8565(a, b);
         default:       pair_of = avg_bytes(a, b);
      endcase
   endfunction

   // Vertical step: stored upper pair with the current lower pair.
   function automatic logic [31:0] rows_of(input logic [1:0] mode,
                                           input logic [31:0] up, input logic [31:0] lo);
      logic [10:0] gsum;
      gsum = {2'd0, up[8:0]} + {2'd0, lo[8:0]} + 11'd2;
      unique case (mode)
         MODE_GRAY8:    rows_of = {24'd0, gsum[9:2]};
         MODE_ARGB8565: rows_of = avg_8565(up, lo);
         default:       rows_of = avg_bytes(up, lo);
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/core/hsbd_line_store.sv */
// Line store holding the horizontal pair results of the last even source row.
// Single port, registered read data; depends on hsbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsbd_line_store (
   input  wire logic                   clock,
   input  wire hsbd_pkg::store_req_type req,
   input  wire logic [31:0]            wr_data,
   output logic [31:0]                 rd_data
);

   logic [31:0] mem [hsbd_pkg::STORE_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= wr_data;
      end
      // Read data holds between reads so a stalled item keeps its upper pair.
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/half_scale_box_downsampler.sv */
// Top level of the half-scale box downsampler: stream ports, register file, counters, pipeline.
// Depends on hsbd_pkg and hsbd_line_store.
//
//   Channel   Dir   Transfer             Contents
//   req_*     in    tvalid & tready      tdata pixel_in, tuser frame_start
//   rsp_*     out   tvalid & tready      tdata pixel_out, tlast row_end, tuser frame_end
//   csr_*     in    psel&penable&pwrite  pixel_mode @0, source_width @4, source_height @8
//
// One item is accepted per cycle while req_tready is high; results pass the middle stage, then
// the result register. The single store port is written or read once per item completing a pair.
// Reset is synchronous; the line store is not cleared and reads only entries of the current frame.
// When the result register is full and not taken, one more result waits in the middle stage and
// req_tready drops until the output moves.
`timescale 1ns / 1ps
`default_nettype none

module half_scale_box_downsampler (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] pixel_in
   input  wire logic        req_tuser,   // [0] frame_start
   // Result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] pixel_out
   output logic             rsp_tlast,   // row_end
   output logic             rsp_tuser,   // [0] frame_end
   // Configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] REG_PIXEL_MODE    = 2'd0;
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd2;

   localparam int CW = hsbd_pkg::COUNT_W;
   localparam int OW = hsbd_pkg::OUT_COL_W;

   // Configuration registers
   logic [1:0]    pixel_mode_ff;
   logic [CW-1:0] source_width_ff;
   logic [CW-1:0] source_height_ff;
   logic          csr_write;

   // Position and held pixel
   logic [CW-1:0] column_count_ff, column_count_in;
   logic [CW-1:0] row_count_ff, row_count_in;
   logic [31:0]   held_pixel_ff, held_pixel_in;

   // Middle stage: pair result waiting for the stored upper pair
   logic          mid_valid_ff, mid_valid_in;
   logic [31:0]   mid_pair_ff;
   logic          mid_row_end_ff;
   logic          mid_frame_end_ff;

   // Result register
   logic          out_valid_ff, out_valid_in;
   logic [31:0]   out_pixel_ff;
   logic          out_row_end_ff;
   logic          out_frame_end_ff;

   logic          accept;
   logic          out_free;
   logic [CW-1:0] col, row;
   logic          active;
   logic [OW-1:0] out_width;
   logic [OW-1:0] out_col;
   logic          pair_ok;
   logic [31:0]   pair;
   logic          row_end;
   logic          frame_end;
   logic [CW-1:0] last_row;
   logic [CW:0]   col_next;
   logic [31:0]   upper_pair;
   hsbd_pkg::store_req_type store_req;

   // ---------------------------------------------------------------- configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff    <= hsbd_pkg::MODE_PACKED;
         source_width_ff  <= '0;
         source_height_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_PIXEL_MODE:    pixel_mode_ff    <= csr_pwdata[1:0];
            REG_SOURCE_WIDTH:  source_width_ff  <= csr_pwdata[CW-1:0];
            REG_SOURCE_HEIGHT: source_height_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_PIXEL_MODE:    csr_prdata = {30'd0, pixel_mode_ff};
         REG_SOURCE_WIDTH:  csr_prdata = {{(32-CW){1'b0}}, source_width_ff};
         REG_SOURCE_HEIGHT: csr_prdata = {{(32-CW){1'b0}}, source_height_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !mid_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------- position logic
   assign col = req_tuser ? '0 : column_count_ff;
   assign row = req_tuser ? '0 : row_count_ff;
   assign active = row < source_height_ff;

   assign out_width = (source_width_ff[CW-1:1] > OW'(hsbd_pkg::STORE_DEPTH)) ?
                      OW'(hsbd_pkg::STORE_DEPTH) : source_width_ff[CW-1:1];
   assign out_col   = col[CW-1:1];

   // A pair exists at an odd column inside both the image and the line store.
   assign pair_ok = active && col[0] && (source_width_ff >= CW'(2)) &&
                    (source_height_ff >= CW'(2)) && (col < source_width_ff) &&
                    (out_col < out_width);

   assign pair      = hsbd_pkg::pair_of(pixel_mode_ff, held_pixel_ff, req_tdata);
   assign last_row  = {source_height_ff[CW-1:1], 1'b0} - CW'(1);
   assign row_end   = out_col == (out_width - OW'(1));
   assign frame_end = row_end && (row == last_row);
   assign col_next  = {1'b0, col} + (CW+1)'(1);

   assign store_req.wr_en = accept && pair_ok && !row[0];
   assign store_req.rd_en = accept && pair_ok && row[0];
   assign store_req.addr  = out_col[hsbd_pkg::STORE_AW-1:0];

   hsbd_line_store u_line_store (
      .clock   (clock),
      .req     (store_req),
      .wr_data (pair),
      .rd_data (upper_pair)
   );

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      held_pixel_in   = held_pixel_ff;
      if (accept) begin
         column_count_in = col;
         row_count_in    = row;
         if (active) begin
            if (!col[0]) begin
               held_pixel_in = req_tdata;
            end
            if (col_next >= {1'b0, source_width_ff}) begin
               column_count_in = '0;
               row_count_in    = row + CW'(1);
            end else begin
               column_count_in = col_next[CW-1:0];
            end
         end
      end
   end

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (accept) begin
         mid_valid_in = store_req.rd_en;
      end else if (out_free) begin
         mid_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         held_pixel_ff   <= '0;
         mid_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         held_pixel_ff   <= held_pixel_in;
         mid_valid_ff    <= mid_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         mid_pair_ff      <= pair;
         mid_row_end_ff   <= row_end;
         mid_frame_end_ff <= frame_end;
      end
      if (out_free && mid_valid_ff) begin
         out_pixel_ff     <= hsbd_pkg::rows_of(pixel_mode_ff, upper_pair, mid_pair_ff);
         out_row_end_ff   <= mid_row_end_ff;
         out_frame_end_ff <= mid_frame_end_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_row_end_ff;
   assign rsp_tuser  = out_frame_end_ff;

   // ---------------------------------------------------------------- checks
   // A waiting middle item must not be lost while the result register is blocked.
   assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !out_free |=> mid_valid_ff)
      else $error("middle stage item dropped while output stalled");

   // The single store port never sees a write and a read together.
   assert property (@(posedge clock) disable iff (reset)
      !(store_req.wr_en && store_req.rd_en))
      else $error("line store write and read in the same cycle");

   // The last pixel of the image is always the last of its output row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   // A result can only appear when a middle item existed in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(mid_valid_ff))
      else $error("result appeared without a middle stage item");

endmodule

`default_nettype wire

/* bench/hsbd_tb_pkg.sv */
// Register map of the half-scale box downsampler as the bench sees it on the csr_ port.
// Shared by the checker and the testbench top; depends on nothing else.
`timescale 1ns / 1ps

package hsbd_tb_pkg;

   typedef enum logic [3:0] {
      REG_PIXEL_MODE    = 4'h0,
      REG_SOURCE_WIDTH  = 4'h4,
      REG_SOURCE_HEIGHT = 4'h8
   } csr_addr_type;

endpackage

/* bench/hsbd_box_average_checker.sv */
// Checker for the half-scale box downsampler: follows register writes and checks reads, predicts
// the 2x2 box averages from the accepted items and compares them with the result channel.
// Depends on hsbd_pkg (mode codes, store depth) and hsbd_tb_pkg (register map).
`timescale 1ns / 1ps

module hsbd_box_average_checker
   import hsbd_pkg::*;
   import hsbd_tb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic [31:0] csr_prdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending_results
);

   typedef struct packed {
      logic [31:0] pixel;
      logic        row_end;
      logic        frame_end;
   } box_result_type;

   box_result_type expected_boxes[$];

   logic [1:0]  cur_mode;
   logic [12:0] cur_width;
   logic [12:0] cur_height;
   logic [31:0] pair_store [STORE_DEPTH];
   logic [31:0] held_pixel;
   int unsigned col_pos;
   int unsigned row_pos;
   int          fail_total = 0;
   int          result_index = 0;

   function automatic logic [7:0] mean_8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = a + b;
      return s[8:1];
   endfunction

   // Floor mean of each 5-6-5 color field on its own.
   function automatic logic [15:0] mean_565(input logic [15:0] a, input logic [15:0] b);
      logic [5:0] blue;
      logic [6:0] green;
      logic [5:0] red;
      blue  = a[4:0] + b[4:0];
      green = a[10:5] + b[10:5];
      red   = a[15:11] + b[15:11];
      return {red[5:1], green[6:1], blue[5:1]};
   endfunction

   // Horizontal step (vertical = 0) or vertical step on a stored pair (vertical = 1).
   // Gray keeps the 9-bit pair sum in the store and rounds only at the end.
   function automatic logic [31:0] fold_pixels(input logic [1:0] mode, input logic [31:0] a,
                                               input logic [31:0] b, input bit vertical);
      logic [10:0] gray_sum;
      logic [31:0] folded;
      int          i;
      folded = 32'd0;
      case (mode)
         MODE_GRAY8: begin
            if (vertical) begin
               gray_sum = a[8:0] + b[8:0] + 11'd2;
               folded   = {24'd0, gray_sum[9:2]};
            end else begin
               gray_sum = a[7:0] + b[7:0];
               folded   = {23'd0, gray_sum[8:0]};
            end
         end
         MODE_ARGB8565: begin
            folded = {8'd0, mean_565(a[23:8], b[23:8]), mean_8(a[7:0], b[7:0])};
         end
         default: begin
            for (i = 0; i < 4; i++)
               folded[8*i +: 8] = mean_8(a[8*i +: 8], b[8*i +: 8]);
         end
      endcase
      return folded;
   endfunction

   task automatic predict_box_average(input logic [31:0] px, input logic frame_start);
      int unsigned width_now;
      int unsigned height_now;
      int unsigned out_width;
      int unsigned out_col;
      int unsigned last_row;
      logic [31:0] pair;
      box_result_type box;
      width_now  = cur_width;
      height_now = cur_height;
      if (frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      // Pixels past the last row are dropped until the next frame start.
      if (row_pos >= height_now)
         return;
      out_width = width_now / 2;
      if (out_width > STORE_DEPTH)
         out_width = STORE_DEPTH;
      out_col = col_pos / 2;
      if (col_pos % 2 == 0) begin
         held_pixel = px;
      end else if (width_now >= 2 && height_now >= 2 && col_pos < width_now &&
                   out_col < out_width) begin
         pair = fold_pixels(cur_mode, held_pixel, px, 1'b0);
         if (row_pos % 2 == 0) begin
            pair_store[out_col] = pair;
         end else begin
            last_row      = (height_now / 2) * 2 - 1;
            box.pixel     = fold_pixels(cur_mode, pair_store[out_col], pair, 1'b1);
            box.row_end   = (out_col == out_width - 1);
            box.frame_end = box.row_end && (row_pos == last_row);
            expected_boxes.push_back(box);
         end
      end
      if (col_pos + 1 >= width_now) begin
         col_pos = 0;
         row_pos = (row_pos + 1) & 32'h1fff;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic report_mismatch(input string what);
      fail_total++;
      if (fail_total <= 10)
         $display("%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : watch_channels
      box_result_type want;
      logic [31:0] reg_value;
      if (reset) begin
         cur_mode   = MODE_PACKED;
         cur_width  = 13'd0;
         cur_height = 13'd0;
         held_pixel = 32'd0;
         col_pos    = 0;
         row_pos    = 0;
         expected_boxes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            reg_value = csr_prdata;
            case (csr_paddr)
               REG_PIXEL_MODE: begin
                  if (csr_pwrite) cur_mode = csr_pwdata[1:0];
                  reg_value = {30'd0, cur_mode};
               end
               REG_SOURCE_WIDTH: begin
                  if (csr_pwrite) cur_width = csr_pwdata[12:0];
                  reg_value = {19'd0, cur_width};
               end
               REG_SOURCE_HEIGHT: begin
                  if (csr_pwrite) cur_height = csr_pwdata[12:0];
                  reg_value = {19'd0, cur_height};
               end
               default: ;
            endcase
            if (!csr_pwrite && csr_prdata !== reg_value)
               report_mismatch($sformatf("register %h read %h, expected %h",
                                         csr_paddr, csr_prdata, reg_value));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_boxes.size() == 0) begin
               report_mismatch($sformatf("unexpected result pixel %h row_end %b frame_end %b",
                                         rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               want = expected_boxes.pop_front();
               if (rsp_tdata !== want.pixel || rsp_tlast !== want.row_end ||
                   rsp_tuser !== want.frame_end)
                  report_mismatch($sformatf({"result %0d: expected pixel %h row_end %b ",
                                             "frame_end %b, got pixel %h row_end %b ",
                                             "frame_end %b"}, result_index, want.pixel,
                                            want.row_end, want.frame_end, rsp_tdata,
                                            rsp_tlast, rsp_tuser));
            end
            result_index++;
         end
         if (req_tvalid && req_tready)
            predict_box_average(req_tdata, req_tuser);
      end
      fail_count      <= fail_total;
      pending_results <= expected_boxes.size();
   end

endmodule

/* bench/half_scale_box_downsampler_tb.sv */
// Testbench top of the half-scale box downsampler: clock, reset, register setup and pixel stimulus.
// Depends on hsbd_pkg, hsbd_tb_pkg, hsbd_box_average_checker and the block itself.
`timescale 1ns / 1ps

module half_scale_box_downsampler_tb;
   import hsbd_pkg::*;
   import hsbd_tb_pkg::*;

   localparam int RANDOM_ITEMS = 880;
   localparam int TAIL_START   = 760;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;    // [31:0] pixel_in
   logic        req_tuser = 1'b0;     // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] pixel_out
   logic        rsp_tlast;            // row_end
   logic        rsp_tuser;            // [0] frame_end
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          chk_failures;
   int          chk_pending;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   bit          hold_off_req = 1'b0;
   int          random_items = 0;
   int unsigned cycle_count;

   always #5 clock = ~clock;

   half_scale_box_downsampler i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   hsbd_box_average_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .fail_count      (chk_failures),
      .pending_results (chk_pending)
   );

   function automatic logic [31:0] next_pixel();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // Mostly small images, now and then a tiny or a larger one.
   function automatic int pick_dim(input int usual_max, input int big_max);
      case ($urandom_range(0, 19))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(usual_max + 1, big_max);
         default: return $urandom_range(2, usual_max);
      endcase
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 25;
         default: return 50;
      endcase
   endfunction

   // Each transfer ends idle, with psel and penable low, so that back-to-back calls never collide.
   task automatic write_reg(input csr_addr_type addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_reg(input csr_addr_type addr);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_setup(input logic [1:0] mode, input int w, input int h);
      write_reg(REG_PIXEL_MODE, {30'd0, mode});
      write_reg(REG_SOURCE_WIDTH, w);
      write_reg(REG_SOURCE_HEIGHT, h);
      read_reg(REG_PIXEL_MODE);
      read_reg(REG_SOURCE_WIDTH);
      read_reg(REG_SOURCE_HEIGHT);
   endtask

   task automatic send_item(input logic [31:0] px, input logic frame_start);
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(input int count);
      repeat (count) send_item(next_pixel(), 1'b0);
   endtask

   task automatic send_frame(input int count);
      send_item(next_pixel(), 1'b1);
      send_run(count - 1);
   endtask

   // One 2x2 image in raster order.
   task automatic send_quad(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d);
      send_item(a, 1'b1);
      send_item(b, 1'b0);
      send_item(c, 1'b0);
      send_item(d, 1'b0);
   endtask

   // Items that produce nothing may still be in the pipeline when the last result leaves,
   // so the task keeps waiting after the checker has no results pending.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chk_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** half_scale_box_downsampler: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [1:0] mode;
      int         w;
      int         h;
      int         frame_len;
      int         style;
      int         sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gap_pct   = 20;
      rsp_stall_pct = 20;

      // Field extremes and rounding in every mode on the smallest image.
      load_setup(MODE_GRAY8, 2, 2);
      send_quad(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_quad(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_quad(32'hffff_ff02, 32'h0000_0000, 32'h0000_00ff, 32'h0000_00fe);
      wait_drained();
      load_setup(MODE_ARGB8565, 2, 2);
      send_quad(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
      wait_drained();
      load_setup(MODE_PACKED, 2, 2);
      send_quad(32'hffff_ffff, 32'h0000_0000, 32'h8000_0001, 32'hffff_ffff);
      wait_drained();
      load_setup(MODE_PACKED_B, 2, 2);
      send_quad(32'h0123_4567, 32'hfedc_ba98, 32'hffff_ffff, 32'h0000_0000);
      wait_drained();

      // Odd last column and row are dropped; pixels past the image are ignored.
      load_setup(MODE_PACKED, 5, 3);
      send_frame(15);
      send_run(3);
      wait_drained();

      // Images narrower or shorter than two pixels give nothing.
      load_setup(MODE_GRAY8, 1, 6);
      send_frame(6);
      wait_drained();
      load_setup(MODE_ARGB8565, 6, 1);
      send_frame(6);
      wait_drained();
      load_setup(MODE_PACKED, 0, 3);
      send_frame(4);
      wait_drained();
      load_setup(MODE_GRAY8, 4, 0);
      send_frame(4);
      wait_drained();

      // Mode changes between the two rows of a block.
      load_setup(MODE_PACKED, 4, 2);
      send_frame(4);
      wait_drained();
      write_reg(REG_PIXEL_MODE, {30'd0, MODE_GRAY8});
      send_run(4);
      wait_drained();
      load_setup(MODE_GRAY8, 6, 2);
      send_frame(6);
      wait_drained();
      write_reg(REG_PIXEL_MODE, {30'd0, MODE_ARGB8565});
      send_run(6);
      wait_drained();
      load_setup(MODE_ARGB8565, 2, 2);
      send_frame(2);
      wait_drained();
      write_reg(REG_PIXEL_MODE, {30'd0, MODE_PACKED});
      send_run(2);
      wait_drained();

      // Width shrinks below the current column: the row ends after the next pixel.
      load_setup(MODE_GRAY8, 8, 4);
      send_frame(5);
      wait_drained();
      write_reg(REG_SOURCE_WIDTH, 4);
      send_run(13);
      wait_drained();
      // Width grows during the first row.
      load_setup(MODE_ARGB8565, 4, 4);
      send_frame(2);
      wait_drained();
      write_reg(REG_SOURCE_WIDTH, 8);
      send_run(30);
      wait_drained();
      // Height shrinks after two rows, so the frame ends early.
      load_setup(MODE_PACKED, 4, 6);
      send_frame(8);
      wait_drained();
      write_reg(REG_SOURCE_HEIGHT, 4);
      send_run(8);
      wait_drained();

      // The receiver holds off while a long frame keeps coming, so the input stalls.
      load_setup(MODE_PACKED, 16, 8);
      hold_off_req = 1'b1;
      send_frame(128);
      wait_drained();

      // A long row and a tall, narrow image.
      req_gap_pct   = 5;
      rsp_stall_pct = 5;
      load_setup(MODE_GRAY8, 200, 2);
      send_frame(200 * 2);
      wait_drained();
      load_setup(MODE_ARGB8565, 2, 120);
      send_frame(2 * 120);
      wait_drained();

      // Random setups, each followed by a few frames; most are complete, some are cut short
      // or trail extra pixels.
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= TAIL_START) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = pick_pct();
            rsp_stall_pct = pick_pct();
         end
         mode = 2'($urandom_range(0, 3));
         w    = pick_dim(12, 24);
         h    = pick_dim(8, 12);
         load_setup(mode, w, h);
         repeat ($urandom_range(1, 4)) begin
            frame_len = (w * h == 0) ? $urandom_range(1, 6) : w * h;
            style     = $urandom_range(0, 19);
            if (style < 3 && frame_len > 1) begin
               sent = $urandom_range(1, frame_len - 1);
               send_frame(sent);
            end else begin
               sent = frame_len;
               send_frame(sent);
               if (style >= 17)
                  send_run($urandom_range(1, 5));
            end
            random_items += sent;
         end
         wait_drained();
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (chk_failures == 0 && chk_pending == 0)
         $display("** half_scale_box_downsampler: PASSED **");
      else
         $display("** half_scale_box_downsampler: FAILED **");
      $finish;
   end

endmodule
